>>> hdl/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/lde_pkg.sv
package lde_pkg;

  localparam int unsigned NodeSlotsDef = 256;
  localparam int unsigned DataBitsDef  = 32;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned PayW    = 32;
  localparam int unsigned HandleW = 8;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CountW  = 9;
  localparam int unsigned InW     = 48;
  localparam int unsigned OutW    = 56;

  typedef enum logic [2:0] {
    CMD_APPEND  = 3'd0,
    CMD_PREPEND = 3'd1,
    CMD_POP     = 3'd2,
    CMD_SHIFT   = 3'd3,
    CMD_REMOVE  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOT_LIVE = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture input item, issue memory reads
    logic exec;   // perform update with read data
  } lde_ctrl_t;

endpackage

>>> hdl/lde_datapath.sv
module lde_datapath import lde_pkg::*; #(
  parameter int unsigned NodeSlots = NodeSlotsDef,
  parameter int unsigned DataBits  = DataBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lde_ctrl_t           ctrl_i,
  input  logic [CmdW-1:0]     cmd_i,
  input  logic [PayW-1:0]     payload_i,
  input  logic [HandleW-1:0]  handle_i,
  output logic [StatW-1:0]    status_o,
  output logic [PayW-1:0]     data_o,
  output logic [HandleW-1:0]  new_handle_o,
  output logic [CountW-1:0]   count_o
);

  localparam int unsigned SW = (NodeSlots > 1) ? $clog2(NodeSlots) : 1;
  localparam int unsigned CW = $clog2(NodeSlots + 1);

  logic [SW-1:0]       next_mem [NodeSlots];
  logic [SW-1:0]       prev_mem [NodeSlots];
  logic [DataBits-1:0] data_mem [NodeSlots];
  logic [NodeSlots-1:0] live_q;

  logic [SW-1:0] head_q, tail_q, recyc_q;
  logic [CW-1:0] live_cnt_q, fresh_q;

  logic [CmdW-1:0]     cmd_q;
  logic [DataBits-1:0] pay_q;
  logic [SW-1:0]       sel_q;   // node read in stage one
  logic                hlive_q; // remove target live and in range
  logic [SW-1:0]       rd_next_q, rd_prev_q;
  logic [DataBits-1:0] rd_data_q;

  logic [SW-1:0]       sel_d;
  logic                in_range;

  always_comb begin
    in_range = ({{(32-HandleW){1'b0}}, handle_i} < NodeSlots);
    case (cmd_i)
      CMD_APPEND, CMD_PREPEND: sel_d = recyc_q;
      CMD_POP:                 sel_d = tail_q;
      CMD_SHIFT:               sel_d = head_q;
      default:                 sel_d = SW'(handle_i);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q     <= cmd_i;
      pay_q     <= DataBits'(payload_i);
      sel_q     <= sel_d;
      rd_next_q <= next_mem[sel_d];
      rd_prev_q <= prev_mem[sel_d];
      rd_data_q <= data_mem[sel_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hlive_q <= 1'b0;
    end else if (ctrl_i.load) begin
      hlive_q <= in_range && live_q[sel_d];
    end
  end

  // execute stage
  logic          is_add, is_take, is_rem, use_recyc, can_add, do_unlink;
  logic [SW-1:0] new_slot, s;

  always_comb begin
    is_add    = (cmd_q == CMD_APPEND) || (cmd_q == CMD_PREPEND);
    is_take   = (cmd_q == CMD_POP) || (cmd_q == CMD_SHIFT);
    is_rem    = (cmd_q == CMD_REMOVE);
    use_recyc = fresh_q > live_cnt_q;
    can_add   = use_recyc || (fresh_q < CW'(NodeSlots));
    new_slot  = use_recyc ? recyc_q : fresh_q[SW-1:0];
    s         = sel_q;
    do_unlink = (is_take && live_cnt_q != '0) || (is_rem && hlive_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      if (is_add && can_add) begin
        data_mem[new_slot] <= pay_q;
        if (live_cnt_q == '0) begin
          next_mem[new_slot] <= new_slot;
          prev_mem[new_slot] <= new_slot;
        end else if (cmd_q == CMD_APPEND) begin
          next_mem[tail_q]   <= new_slot;
          prev_mem[new_slot] <= tail_q;
        end else begin
          prev_mem[head_q]   <= new_slot;
          next_mem[new_slot] <= head_q;
        end
      end else if (do_unlink) begin
        next_mem[s] <= recyc_q;
        if (live_cnt_q != CW'(1) && s != head_q && s != tail_q) begin
          next_mem[rd_prev_q] <= rd_next_q;
          prev_mem[rd_next_q] <= rd_prev_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q       <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      recyc_q      <= '0;
      live_cnt_q   <= '0;
      fresh_q      <= '0;
      status_o     <= ST_OK;
      data_o       <= '0;
      new_handle_o <= '0;
      count_o      <= '0;
    end else if (ctrl_i.exec) begin
      status_o     <= ST_OK;
      data_o       <= '0;
      new_handle_o <= '0;
      count_o      <= CountW'(live_cnt_q);
      if (is_add) begin
        if (!can_add) begin
          status_o <= ST_FULL;
        end else begin
          live_q[new_slot] <= 1'b1;
          if (use_recyc) begin
            recyc_q <= rd_next_q;
          end else begin
            fresh_q <= fresh_q + CW'(1);
          end
          if (live_cnt_q == '0) begin
            head_q <= new_slot;
            tail_q <= new_slot;
          end else if (cmd_q == CMD_APPEND) begin
            tail_q <= new_slot;
          end else begin
            head_q <= new_slot;
          end
          live_cnt_q   <= live_cnt_q + CW'(1);
          count_o      <= CountW'(live_cnt_q + CW'(1));
          new_handle_o <= HandleW'(new_slot);
        end
      end else if (is_take && live_cnt_q == '0) begin
        status_o <= ST_EMPTY;
      end else if (is_rem && !hlive_q) begin
        status_o <= ST_NOT_LIVE;
      end else if (do_unlink) begin
        if (is_take) begin
          data_o <= PayW'(rd_data_q);
        end
        if (live_cnt_q == CW'(1)) begin
          head_q <= '0;
          tail_q <= '0;
        end else if (s == head_q) begin
          head_q <= rd_next_q;
        end else if (s == tail_q) begin
          tail_q <= rd_prev_q;
        end
        live_q[s]  <= 1'b0;
        recyc_q    <= s;
        live_cnt_q <= live_cnt_q - CW'(1);
        count_o    <= CountW'(live_cnt_q - CW'(1));
      end
    end
  end

endmodule

>>> hdl/lde_ctrl.sv
module lde_ctrl import lde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lde_ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctrl_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        ctrl_o.exec = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        ctrl_o.load = out_ready_i && in_valid_i;
        if (out_ready_i) state_d = in_valid_i ? S_EXEC : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/linked_deque_engine_core.sv
// Bounded doubly linked deque in a pool of NodeSlots slots. Each input transfer
// carries one command (append, prepend, pop, shift, remove by handle) and gives
// exactly one result transfer. Each command first reads the selected node's links
// and data from the link memories, then writes the neighbours and updates head,
// tail and free list. The next command is taken in the cycle its predecessor's
// result is taken, so no new command is taken while one is in flight. No
// clearing pass after reset.
module linked_deque_engine_core import lde_pkg::*; #(
  parameter int unsigned NodeSlots = NodeSlotsDef,
  parameter int unsigned DataBits  = DataBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [InW-1:0] s_axis_tdata,   // cmd[2:0], payload[34:3], target_handle[42:35], pad
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata   // status, data_out, new_handle, entry_count, pad
);

  lde_ctrl_t          ctrl;
  logic [StatW-1:0]   status;
  logic [PayW-1:0]    data;
  logic [HandleW-1:0] nh;
  logic [CountW-1:0]  cnt;

  lde_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  lde_datapath #(.NodeSlots(NodeSlots), .DataBits(DataBits)) u_dp (
    .clk_i, .rst_ni,
    .ctrl_i       (ctrl),
    .cmd_i        (s_axis_tdata[2:0]),
    .payload_i    (s_axis_tdata[34:3]),
    .handle_i     (s_axis_tdata[42:35]),
    .status_o     (status),
    .data_o       (data),
    .new_handle_o (nh),
    .count_o      (cnt)
  );

  assign m_axis_tdata = {5'd0, cnt, nh, data, status};

endmodule

>>> hdl/lde_checker.sv
`include "assert_macros.svh"
module lde_checker import lde_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  `ASSERT_CLK(a_result_follows, s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid, "no result")
  `ASSERT_CLK(a_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed")
  `ASSERT_CLK(a_no_take_pending, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "over-accept")
  `ASSERT_CLK(a_pad, m_axis_tvalid |-> m_axis_tdata[OutW-1:51] == '0, "pad bits")
  `ASSERT_RST(a_rst, !rst_ni |-> !m_axis_tvalid, "valid in reset")

endmodule

bind linked_deque_engine_core lde_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

>>> dv/linked_deque_engine_core_tb.sv
`timescale 1ns / 100ps

module linked_deque_engine_core_tb;
  import lde_pkg::*;

  typedef struct packed {
    logic [8:0]  count;
    logic [7:0]  handle;
    logic [31:0] data;
    status_e     status;
  } deque_result_t;

  class deque_mirror;
    logic [7:0]  head_q, tail_q, recyc_q;
    logic [8:0]  count_q, fresh_q;
    logic [7:0]  nxt[256];
    logic [7:0]  prv[256];
    logic [31:0] word[256];
    bit          live[256];
    deque_result_t pending[$];
    int          errors;

    function new();
      head_q = 0; tail_q = 0; recyc_q = 0; count_q = 0; fresh_q = 0;
      errors = 0;
      foreach (live[i]) live[i] = 0;
    endfunction

    function void unlink(logic [7:0] s);
      logic [7:0] p, n;
      if (count_q == 1) begin
        head_q = 0;
        tail_q = 0;
      end else if (s == head_q) begin
        head_q = nxt[s];
      end else if (s == tail_q) begin
        tail_q = prv[s];
      end else begin
        p = prv[s];
        n = nxt[s];
        nxt[p] = n;
        prv[n] = p;
      end
      live[s] = 0;
      nxt[s] = recyc_q;
      recyc_q = s;
      count_q--;
    endfunction

    function void note_command(logic [2:0] cmd, logic [31:0] pay, logic [7:0] tgt);
      deque_result_t r;
      logic [7:0] s;
      bit got;
      r = '{status: ST_OK, data: '0, handle: '0, count: '0};
      case (cmd)
        CMD_APPEND, CMD_PREPEND: begin
          got = 1;
          if (fresh_q > count_q) begin
            s = recyc_q;
            recyc_q = nxt[s];
          end else if (fresh_q < 256) begin
            s = fresh_q[7:0];
            fresh_q++;
          end else begin
            got = 0;
          end
          if (!got) begin
            r.status = ST_FULL;
          end else begin
            word[s] = pay;
            live[s] = 1;
            nxt[s] = s;
            prv[s] = s;
            if (count_q == 0) begin
              head_q = s;
              tail_q = s;
            end else if (cmd == CMD_APPEND) begin
              nxt[tail_q] = s;
              prv[s] = tail_q;
              tail_q = s;
            end else begin
              prv[head_q] = s;
              nxt[s] = head_q;
              head_q = s;
            end
            count_q++;
            r.handle = s;
          end
        end
        CMD_POP, CMD_SHIFT: begin
          if (count_q == 0) begin
            r.status = ST_EMPTY;
          end else begin
            s = (cmd == CMD_POP) ? tail_q : head_q;
            r.data = word[s];
            unlink(s);
          end
        end
        CMD_REMOVE: begin
          if (!live[tgt]) r.status = ST_NOT_LIVE;
          else unlink(tgt);
        end
        default: ;
      endcase
      r.count = count_q;
      pending.push_back(r);
    endfunction

    function void check_result(deque_result_t act);
      deque_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (act.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, act.status);
        errors++;
      end
      if (act.data !== exp.data) begin
        $display("%0t: data_out exp %h got %h", $time, exp.data, act.data);
        errors++;
      end
      if (act.handle !== exp.handle) begin
        $display("%0t: new_handle exp %0d got %0d", $time, exp.handle, act.handle);
        errors++;
      end
      if (act.count !== exp.count) begin
        $display("%0t: entry_count exp %0d got %0d", $time, exp.count, act.count);
        errors++;
      end
    endfunction

    function logic [7:0] any_live();
      int start;
      start = $urandom_range(0, 255);
      for (int i = 0; i < 256; i++)
        if (live[(start + i) % 256]) return 8'((start + i) % 256);
      return start[7:0];
    endfunction
  endclass

  logic            clk_i = 0;
  logic            rst_ni = 0;
  logic            s_axis_tvalid = 0;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 0;
  logic [OutW-1:0] m_axis_tdata;

  deque_mirror mirror = new();
  bit          idling = 1;
  int          quiet_cycles = 0;

  linked_deque_engine_core dut (.*);

  always #5 clk_i = ~clk_i;

  task automatic pause_sender();
    if (idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic send_command(logic [2:0] cmd, logic [31:0] pay, logic [7:0] tgt);
    pause_sender();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, tgt, pay, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    mirror.note_command(cmd, pay, tgt);
  endtask

  task automatic random_command(int grow_pct);
    logic [2:0] cmd;
    logic [7:0] tgt;
    int roll;
    roll = $urandom_range(0, 99);
    tgt  = 8'($urandom);
    if (roll < grow_pct) cmd = 3'($urandom_range(0, 1));
    else if (roll < grow_pct + (100 - grow_pct) / 2) cmd = 3'($urandom_range(2, 3));
    else if (roll < 97) begin
      cmd = CMD_REMOVE;
      if ($urandom_range(0, 3) != 0) tgt = mirror.any_live();
    end else cmd = 3'($urandom_range(5, 7));
    send_command(cmd, $urandom, tgt);
  endtask

  // receiver: random stall bursts, checks each transfer
  always @(posedge clk_i) begin
    static int stall = 0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) mirror.check_result(m_axis_tdata[50:0]);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles > 2000) begin
        $display("== FAIL ==");
        $finish;
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(CMD_POP, 32'hFFFF_FFFF, 8'd0);
    send_command(CMD_SHIFT, 32'h0, 8'd0);
    send_command(CMD_REMOVE, 32'h0, 8'd0);
    send_command(CMD_APPEND, 32'hFFFF_FFFF, 8'hFF);
    send_command(CMD_PREPEND, 32'h0000_0000, 8'h00);
    send_command(CMD_APPEND, 32'hA5A5_5A5A, 8'h00);
    send_command(CMD_REMOVE, 32'h0, 8'hFF);
    send_command(CMD_REMOVE, 32'h0, 8'd1);
    send_command(3'd5, 32'hFFFF_FFFF, 8'hFF);
    send_command(3'd6, 32'h1234_5678, 8'h00);
    send_command(3'd7, 32'h0, 8'h0F);
    send_command(CMD_POP, 32'h0, 8'd0);
    send_command(CMD_SHIFT, 32'h0, 8'd0);
    send_command(CMD_APPEND, 32'h5A5A_A5A5, 8'h00);
    send_command(CMD_PREPEND, 32'h0F0F_F0F0, 8'h00);
    send_command(CMD_APPEND, 32'h1111_2222, 8'h00);
    send_command(CMD_REMOVE, 32'h0, 8'd2);
    send_command(CMD_POP, 32'h0, 8'd0);
    send_command(CMD_SHIFT, 32'h0, 8'd0);

    // fill to an exhausted pool, then mixed traffic
    repeat (320) random_command(92);
    repeat (150) random_command(35);
    repeat (150) random_command(55);
    idling = 0;
    repeat (110) random_command(50);

    s_axis_tvalid <= 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/lde_pkg.sv
hdl/lde_datapath.sv
hdl/lde_ctrl.sv
hdl/linked_deque_engine_core.sv
hdl/lde_checker.sv
dv/linked_deque_engine_core_tb.sv
